// ----- sv/pec_pkg.sv -----
`default_nettype none
package pec_pkg;

   localparam int SAMPLE_BITS_DEF    = 16;
   localparam int GAIN_FRAC_BITS_DEF = 16;

   localparam int CHAN_W     = 16;
   localparam int GAIN_W     = 24;
   localparam int SMAX_W     = 16;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);
   localparam logic [SMAX_W-1:0] SMAX_RESET = SMAX_W'(255);

   typedef enum logic [MODE_W-1:0] {
      MODE_TRIPLE = 2'd0,
      MODE_LUMA   = 2'd1,
      MODE_INDEP  = 2'd2,
      MODE_SPARE  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN = 2'd0,
      CSR_SMAX = 2'd1,
      CSR_MODE = 2'd2
   } csr_index_type;

   typedef logic [1:0] pos_type;

   typedef struct packed {
      logic [CHAN_W-1:0] chan_a;
      logic [CHAN_W-1:0] chan_b;
      logic [CHAN_W-1:0] chan_c;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_a;
      logic [CHAN_W-1:0] out_b;
      logic [CHAN_W-1:0] out_c;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      logic    blend;
      pos_type md_pos;
   } ctl_type;

endpackage
`default_nettype wire

// ----- sv/pec_front.sv -----
`default_nettype none
module pec_front import pec_pkg::*; #(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire req_type                      in_req,
   input  wire logic [GAIN_W-1:0]            gain,
   input  wire logic [SAMPLE_BITS-1:0]       smax,
   input  wire mode_type                     mode,
   output ctl_type                           out_ctl,
   output logic [2:0][SAMPLE_BITS-1:0]       out_r,
   output logic [SAMPLE_BITS+GAIN_FRAC_BITS-1:0] out_e,
   output logic [SAMPLE_BITS-1:0]            out_d,
   output logic [SAMPLE_BITS-1:0]            out_md_lo,
   output logic [SAMPLE_BITS+GAIN_FRAC_BITS-1:0] out_ms_e
);
   localparam int S  = SAMPLE_BITS;
   localparam int F  = GAIN_FRAC_BITS;
   localparam int PW = S + GAIN_W;
   localparam int EW = S + F;

   // stage 1: saturate and sort
   logic [2:0][S-1:0] raw;
   logic [2:0][S-1:0] chan_in, chan1_ff;
   logic [S-1:0]      lo_in, hi_in, lo1_ff, hi1_ff;
   pos_type           lo_pos_in, hi_pos_in, md_pos_in;
   pos_type           lo_pos1_ff, hi_pos1_ff, md_pos1_ff;
   logic              vld1_ff;

   always_comb begin
      raw[0] = in_req.chan_a[S-1:0];
      raw[1] = in_req.chan_b[S-1:0];
      raw[2] = in_req.chan_c[S-1:0];
      for (int i = 0; i < 3; i++) begin
         chan_in[i] = (raw[i] > smax) ? smax : raw[i];
      end
      hi_in     = '0;
      lo_in     = smax;
      hi_pos_in = 2'd0;
      lo_pos_in = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (chan_in[i] > hi_in) begin
            hi_in     = chan_in[i];
            hi_pos_in = 2'(i);
         end
         if (chan_in[i] < lo_in) begin
            lo_in     = chan_in[i];
            lo_pos_in = 2'(i);
         end
      end
      if (lo_pos_in != 2'd0 && hi_pos_in != 2'd0) begin
         md_pos_in = 2'd0;
      end else if (lo_pos_in != 2'd1 && hi_pos_in != 2'd1) begin
         md_pos_in = 2'd1;
      end else begin
         md_pos_in = 2'd2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
      end
      chan1_ff   <= chan_in;
      lo1_ff     <= lo_in;
      hi1_ff     <= hi_in;
      lo_pos1_ff <= lo_pos_in;
      hi_pos1_ff <= hi_pos_in;
      md_pos1_ff <= md_pos_in;
   end

   // stage 2: scale each channel
   logic [PW-1:0]     prod_in [3];
   logic [PW-1:0]     prod2_ff [3];
   logic [2:0][S-1:0] chan2_ff;
   logic [S-1:0]      lo2_ff, hi2_ff;
   pos_type           lo_pos2_ff, hi_pos2_ff, md_pos2_ff;
   logic              vld2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = PW'(chan1_ff[i]) * PW'(gain);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
      prod2_ff   <= prod_in;
      chan2_ff   <= chan1_ff;
      lo2_ff     <= lo1_ff;
      hi2_ff     <= hi1_ff;
      lo_pos2_ff <= lo_pos1_ff;
      hi_pos2_ff <= hi_pos1_ff;
      md_pos2_ff <= md_pos1_ff;
   end

   // stage 3: classify and clip
   logic [PW-1:0]     ms, e, h, half, rnd, ms_e_w;
   logic [PW-1:0]     scaled [3];
   logic [2:0][S-1:0] sat;
   logic              all_max, linear;
   ctl_type           ctl_in, ctl3_ff;
   logic [2:0][S-1:0] r_in, r3_ff;
   logic [S-1:0]      d_in, md_lo_in, d3_ff, md_lo3_ff;
   logic [EW-1:0]     e3_ff, ms_e3_ff;

   always_comb begin
      ms      = PW'(smax) << F;
      e       = prod2_ff[lo_pos2_ff];
      h       = prod2_ff[hi_pos2_ff];
      half    = PW'(1) << (F - 1);
      rnd     = (e + half) >> F;
      ms_e_w  = ms - e;
      all_max = e > ms;
      linear  = h <= ms;
      for (int i = 0; i < 3; i++) begin
         scaled[i] = prod2_ff[i] >> F;
         sat[i]    = (scaled[i] > PW'(smax)) ? smax : scaled[i][S-1:0];
      end
      ctl_in.valid  = vld2_ff;
      ctl_in.blend  = 1'b0;
      ctl_in.md_pos = md_pos2_ff;
      r_in          = sat;
      unique case (mode)
         MODE_TRIPLE: begin
            if (all_max) begin
               r_in = {smax, smax, smax};
            end else if (linear) begin
               for (int i = 0; i < 3; i++) begin
                  r_in[i] = scaled[i][S-1:0];
               end
            end else begin
               r_in             = '0;
               r_in[lo_pos2_ff] = rnd[S-1:0];
               r_in[hi_pos2_ff] = smax;
               ctl_in.blend     = 1'b1;
            end
         end
         MODE_LUMA: begin
            r_in[0] = sat[0];
            r_in[1] = chan2_ff[1];
            r_in[2] = chan2_ff[2];
         end
         default: begin
            r_in = sat;
         end
      endcase
      d_in     = hi2_ff - lo2_ff;
      if (d_in == '0) begin
         d_in = S'(1);
      end
      md_lo_in = chan2_ff[md_pos2_ff] - lo2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else begin
         ctl3_ff <= ctl_in;
      end
      r3_ff     <= r_in;
      d3_ff     <= d_in;
      md_lo3_ff <= md_lo_in;
      e3_ff     <= e[EW-1:0];
      ms_e3_ff  <= ms_e_w[EW-1:0];
   end

   assign out_ctl   = ctl3_ff;
   assign out_r     = r3_ff;
   assign out_e     = e3_ff;
   assign out_d     = d3_ff;
   assign out_md_lo = md_lo3_ff;
   assign out_ms_e  = ms_e3_ff;

endmodule
`default_nettype wire

// ----- sv/pec_blend.sv -----
`default_nettype none
module pec_blend import pec_pkg::*; #(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ctl_type                              in_ctl,
   input  wire logic [2:0][SAMPLE_BITS-1:0]          in_r,
   input  wire logic [SAMPLE_BITS+GAIN_FRAC_BITS-1:0] in_e,
   input  wire logic [SAMPLE_BITS-1:0]               in_d,
   input  wire logic [SAMPLE_BITS-1:0]               in_md_lo,
   input  wire logic [SAMPLE_BITS+GAIN_FRAC_BITS-1:0] in_ms_e,
   output ctl_type                                   out_ctl,
   output logic [2:0][SAMPLE_BITS-1:0]               out_r,
   output logic [2*SAMPLE_BITS+GAIN_FRAC_BITS+1:0]   out_num,
   output logic [SAMPLE_BITS+GAIN_FRAC_BITS-1:0]     out_den
);
   localparam int S  = SAMPLE_BITS;
   localparam int F  = GAIN_FRAC_BITS;
   localparam int EW = S + F;
   localparam int NW = 2 * S + F + 2;

   // stage 1: the two products of the interpolation
   logic [EW+S-1:0]   t1_ff, t2_ff;
   logic [S-1:0]      d1_ff;
   ctl_type           ctl1_ff;
   logic [2:0][S-1:0] r1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else begin
         ctl1_ff <= in_ctl;
      end
      t1_ff <= (EW+S)'(in_e) * (EW+S)'(in_d);
      t2_ff <= (EW+S)'(in_md_lo) * (EW+S)'(in_ms_e);
      d1_ff <= in_d;
      r1_ff <= in_r;
   end

   // stage 2: numerator with rounding term, scaled divisor
   logic [NW-1:0]     num_in, num2_ff;
   logic [EW-1:0]     den2_ff;
   ctl_type           ctl2_ff;
   logic [2:0][S-1:0] r2_ff;

   assign num_in = NW'(t1_ff) + NW'(t2_ff) + (NW'(d1_ff) << (F - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else begin
         ctl2_ff <= ctl1_ff;
      end
      num2_ff <= num_in;
      den2_ff <= EW'(d1_ff) << F;
      r2_ff   <= r1_ff;
   end

   assign out_ctl = ctl2_ff;
   assign out_r   = r2_ff;
   assign out_num = num2_ff;
   assign out_den = den2_ff;

endmodule
`default_nettype wire

// ----- sv/pec_div.sv -----
`default_nettype none
module pec_div import pec_pkg::*; #(
   parameter int NUM_W = 2 * SAMPLE_BITS_DEF + GAIN_FRAC_BITS_DEF + 2,
   parameter int DEN_W = SAMPLE_BITS_DEF + GAIN_FRAC_BITS_DEF,
   parameter int QUO_W = SAMPLE_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] in_num,
   input  wire logic [DEN_W-1:0] in_den,
   output logic                  out_valid,
   output logic [QUO_W-1:0]      out_quo
);
   // restoring division, one quotient bit per stage, most significant first
   logic [NUM_W-1:0] rem_ff [QUO_W-1];
   logic [DEN_W-1:0] den_ff [QUO_W-1];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic             vld_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic [NUM_W-1:0] rem_src, shifted;
      logic [DEN_W-1:0] den_src;
      logic [QUO_W-1:0] quo_src, quo_in;
      logic             vld_src, fits;

      if (j == 0) begin : g_first
         assign rem_src = in_num;
         assign den_src = in_den;
         assign quo_src = '0;
         assign vld_src = in_valid;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign den_src = den_ff[j-1];
         assign quo_src = quo_ff[j-1];
         assign vld_src = vld_ff[j-1];
      end

      assign shifted = NUM_W'(den_src) << (QUO_W - 1 - j);
      assign fits    = rem_src >= shifted;

      always_comb begin
         quo_in                = quo_src;
         quo_in[QUO_W - 1 - j] = fits;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_src;
         end
         quo_ff[j] <= quo_in;
      end

      if (j < QUO_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[j] <= fits ? (rem_src - shifted) : rem_src;
            den_ff[j] <= den_src;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];

endmodule
`default_nettype wire

// ----- sv/pixel_exposure_clip_unit.sv -----
`default_nettype none
// throughput: one request per cycle; busy stays low, the receiver cannot stall
// the hue-keeping blend runs through a divider, one quotient bit per stage
// synchronous reset restores the register defaults and clears every pipeline valid bit
module pixel_exposure_clip_unit import pec_pkg::*; #(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   output logic                       rsp_strobe,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int S  = SAMPLE_BITS;
   localparam int F  = GAIN_FRAC_BITS;
   localparam int EW = S + F;
   localparam int NW = 2 * S + F + 2;

   logic [GAIN_W-1:0] gain_ff;
   logic [SMAX_W-1:0] smax_ff;
   mode_type          mode_ff;
   logic [S-1:0]      smax;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign smax      = smax_ff[S-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         smax_ff <= SMAX_RESET;
         mode_ff <= MODE_TRIPLE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GAIN: gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_SMAX: smax_ff <= csr_wdata[SMAX_W-1:0];
            CSR_MODE: mode_ff <= mode_type'(csr_wdata[MODE_W-1:0]);
            default: ;
         endcase
      end
   end

   ctl_type           f_ctl, b_ctl;
   logic [2:0][S-1:0] f_r, b_r;
   logic [EW-1:0]     f_e, f_ms_e, b_den;
   logic [S-1:0]      f_d, f_md_lo, quo;
   logic [NW-1:0]     b_num;
   logic              div_valid;

   pec_front #(
      .SAMPLE_BITS    (S),
      .GAIN_FRAC_BITS (F)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_req    (req_data),
      .gain      (gain_ff),
      .smax      (smax),
      .mode      (mode_ff),
      .out_ctl   (f_ctl),
      .out_r     (f_r),
      .out_e     (f_e),
      .out_d     (f_d),
      .out_md_lo (f_md_lo),
      .out_ms_e  (f_ms_e)
   );

   pec_blend #(
      .SAMPLE_BITS    (S),
      .GAIN_FRAC_BITS (F)
   ) u_blend (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (f_ctl),
      .in_r     (f_r),
      .in_e     (f_e),
      .in_d     (f_d),
      .in_md_lo (f_md_lo),
      .in_ms_e  (f_ms_e),
      .out_ctl  (b_ctl),
      .out_r    (b_r),
      .out_num  (b_num),
      .out_den  (b_den)
   );

   pec_div #(
      .NUM_W (NW),
      .DEN_W (EW),
      .QUO_W (S)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_ctl.valid),
      .in_num    (b_num),
      .in_den    (b_den),
      .out_valid (div_valid),
      .out_quo   (quo)
   );

   // side data alongside the divider
   ctl_type           dl_ctl_ff [S];
   logic [2:0][S-1:0] dl_r_ff [S];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < S; k++) begin
            dl_ctl_ff[k] <= '0;
         end
      end else begin
         dl_ctl_ff[0] <= b_ctl;
         for (int k = 1; k < S; k++) begin
            dl_ctl_ff[k] <= dl_ctl_ff[k-1];
         end
      end
      dl_r_ff[0] <= b_r;
      for (int k = 1; k < S; k++) begin
         dl_r_ff[k] <= dl_r_ff[k-1];
      end
   end

   ctl_type           tail_ctl;
   logic [2:0][S-1:0] fin;
   logic              strobe_ff;
   rsp_type           rsp_in, rsp_ff;

   assign tail_ctl = dl_ctl_ff[S-1];

   always_comb begin
      fin = dl_r_ff[S-1];
      if (tail_ctl.blend) begin
         fin[tail_ctl.md_pos] = quo;
      end
      for (int i = 0; i < 3; i++) begin
         if (fin[i] > smax) begin
            fin[i] = smax;
         end
      end
      rsp_in.out_a = CHAN_W'(fin[0]);
      rsp_in.out_b = CHAN_W'(fin[1]);
      rsp_in.out_c = CHAN_W'(fin[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tail_ctl.valid && div_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

// ----- dv/tb_pixel_exposure_clip_unit.sv -----
`default_nettype none
module tb_pixel_exposure_clip_unit;
   import pec_pkg::*;

   localparam int FRAC      = GAIN_FRAC_BITS_DEF;
   localparam int LATENCY   = SAMPLE_BITS_DEF + 6;
   localparam int RAND_REQS = 1300;
   localparam int PHASES    = 13;

   class exposure_scoreboard;
      logic [GAIN_W-1:0] gain;
      logic [SMAX_W-1:0] smax;
      mode_type          mode;
      rsp_type           pending[$];
      int                errors;
      int                checked;

      function new();
         gain    = GAIN_RESET;
         smax    = SMAX_RESET;
         mode    = MODE_TRIPLE;
         errors  = 0;
         checked = 0;
      endfunction

      function rsp_type expose(req_type r);
         logic [63:0] c[3];
         logic [63:0] q[3];
         logic [63:0] m, g, ms, hi, lo, e, d, num;
         int          hp, lp, mp;
         rsp_type     y;
         m  = 64'(smax);
         g  = 64'(gain);
         ms = m << FRAC;
         c[0] = 64'(r.chan_a);
         c[1] = 64'(r.chan_b);
         c[2] = 64'(r.chan_c);
         for (int i = 0; i < 3; i++) if (c[i] > m) c[i] = m;
         if (mode == MODE_TRIPLE) begin
            hi = 0;
            lo = m;
            hp = 0;
            lp = 0;
            for (int i = 0; i < 3; i++) begin
               if (c[i] > hi) begin
                  hi = c[i];
                  hp = i;
               end
               if (c[i] < lo) begin
                  lo = c[i];
                  lp = i;
               end
            end
            if (lo * g > ms) begin
               for (int i = 0; i < 3; i++) q[i] = m;
            end else if (hi * g <= ms) begin
               for (int i = 0; i < 3; i++) q[i] = (c[i] * g) >> FRAC;
            end else begin
               e = lo * g;
               d = hi - lo;
               if (lp != 0 && hp != 0) mp = 0;
               else if (lp != 1 && hp != 1) mp = 1;
               else mp = 2;
               if (d == 0) d = 1;
               num = e * d + (c[mp] - lo) * (ms - e) + (64'd1 << (FRAC - 1)) * d;
               q[mp] = (num / d) >> FRAC;
               q[lp] = (e + (64'd1 << (FRAC - 1))) >> FRAC;
               q[hp] = m;
            end
         end else if (mode == MODE_LUMA) begin
            q[0] = (c[0] * g) >> FRAC;
            q[1] = c[1];
            q[2] = c[2];
         end else begin
            for (int i = 0; i < 3; i++) q[i] = (c[i] * g) >> FRAC;
         end
         for (int i = 0; i < 3; i++) if (q[i] > m) q[i] = m;
         y.out_a = q[0][CHAN_W-1:0];
         y.out_b = q[1][CHAN_W-1:0];
         y.out_c = q[2][CHAN_W-1:0];
         return y;
      endfunction

      function void note_request(req_type r);
         pending.push_back(expose(r));
      endfunction

      function void check_result(rsp_type a);
         rsp_type x;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, a);
            errors++;
            return;
         end
         x = pending.pop_front();
         checked++;
         if (a.out_a !== x.out_a) begin
            $display("%0t: out_a expected %h actual %h", $time, x.out_a, a.out_a);
            errors++;
         end
         if (a.out_b !== x.out_b) begin
            $display("%0t: out_b expected %h actual %h", $time, x.out_b, a.out_b);
            errors++;
         end
         if (a.out_c !== x.out_c) begin
            $display("%0t: out_c expected %h actual %h", $time, x.out_c, a.out_c);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   exposure_scoreboard pixels_sb;
   int                 csr_writes;

   pixel_exposure_clip_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("tb_pixel_exposure_clip_unit: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) pixels_sb.note_request(req_data);
         if (rsp_strobe) pixels_sb.check_result(rsp_data);
      end
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_pixel(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                             logic [CHAN_W-1:0] c, int gap);
      start          <= 1'b1;
      req_data.chan_a <= a;
      req_data.chan_b <= b;
      req_data.chan_c <= c;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pixels_sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_GAIN: pixels_sb.gain = val[GAIN_W-1:0];
         CSR_SMAX: pixels_sb.smax = val[SMAX_W-1:0];
         default:  pixels_sb.mode = mode_type'(val[MODE_W-1:0]);
      endcase
      repeat ($urandom_range(0, 2)) @(posedge clock);
   endtask

   task automatic set_config(logic [GAIN_W-1:0] g, logic [SMAX_W-1:0] m, mode_type md);
      drain();
      write_csr(CSR_GAIN, CSR_DATA_W'(g));
      write_csr(CSR_SMAX, CSR_DATA_W'(m));
      write_csr(CSR_MODE, CSR_DATA_W'(md));
   endtask

   function automatic logic [CHAN_W-1:0] pick_sample(logic [SMAX_W-1:0] m);
      int p;
      p = $urandom_range(0, 99);
      if (p < 75) return CHAN_W'($urandom_range(0, m));
      if (p < 85) return (p < 80) ? CHAN_W'(0) : CHAN_W'(m);
      return CHAN_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      int p;
      p = $urandom_range(0, 9);
      if (p < 5) return GAIN_W'($urandom_range(16384, 262144));
      if (p < 7) return GAIN_W'($urandom_range(0, 24'hffffff));
      if (p == 7) return GAIN_W'($urandom_range(0, 4096));
      if (p == 8) return 24'hffffff;
      return 24'h010000;
   endfunction

   function automatic logic [SMAX_W-1:0] pick_smax(int ph);
      case (ph % 5)
         0: return 16'hffff;
         1: return 16'd255;
         2: return 16'd1;
         default: return SMAX_W'($urandom_range(1, 65535));
      endcase
   endfunction

   initial begin
      logic [GAIN_W-1:0] g;
      logic [SMAX_W-1:0] m;
      pixels_sb  = new();
      csr_writes = 0;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_GAIN;
      csr_wdata  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: unity gain, 8 bit range, triple mode
      send_pixel(16'd0, 16'd0, 16'd0, 0);
      send_pixel(16'd255, 16'd255, 16'd255, 0);
      send_pixel(16'hffff, 16'h0100, 16'd12, 1);
      send_pixel(16'd17, 16'd200, 16'd99, 0);

      // blend case, ties and full saturation
      set_config(24'h020000, 16'd255, MODE_TRIPLE);
      send_pixel(16'd10, 16'd100, 16'd200, 0);
      send_pixel(16'd200, 16'd10, 16'd100, 0);
      send_pixel(16'd100, 16'd200, 16'd10, 0);
      send_pixel(16'd100, 16'd200, 16'd100, 0);
      send_pixel(16'd130, 16'd250, 16'd140, 0);
      send_pixel(16'd30, 16'd60, 16'd90, 0);

      set_config(24'hffffff, 16'hffff, MODE_LUMA);
      send_pixel(16'hffff, 16'h0000, 16'hffff, 0);
      send_pixel(16'h0001, 16'haaaa, 16'h5555, 0);

      set_config(24'h000000, 16'hffff, MODE_INDEP);
      send_pixel(16'hffff, 16'hffff, 16'hffff, 0);
      set_config(24'h018000, 16'hffff, MODE_SPARE);
      send_pixel(16'h5555, 16'haaaa, 16'hffff, 0);
      send_pixel(16'h0001, 16'h8000, 16'h7fff, 0);

      set_config(24'h030000, 16'd1, MODE_TRIPLE);
      send_pixel(16'd0, 16'd1, 16'd5, 0);
      send_pixel(16'd1, 16'd1, 16'd1, 0);

      for (int ph = 0; ph < PHASES; ph++) begin
         g = pick_gain();
         m = pick_smax(ph);
         set_config(g, m, mode_type'((ph < 8) ? MODE_TRIPLE : $urandom_range(0, 3)));
         for (int k = 0; k < RAND_REQS / PHASES; k++) begin
            send_pixel(pick_sample(m), pick_sample(m), pick_sample(m),
                       ($urandom_range(0, 3) == 0) ? 0 : pick_gap());
         end
      end

      drain();
      $display("checked %0d pixels over %0d register writes in %0d phases",
               pixels_sb.checked, csr_writes, PHASES + 6);
      if (pixels_sb.errors == 0 && pixels_sb.pending.size() == 0) begin
         $display("tb_pixel_exposure_clip_unit: done, clean");
      end else begin
         $display("tb_pixel_exposure_clip_unit: done, errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
